>>> hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int unsigned PRIORITY_BITS    = 8;
  localparam int unsigned PAYLOAD_BITS     = 16;
  localparam int unsigned COUNT_FIELD_BITS = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } spq_status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } spq_op_e;

  typedef struct packed {
    logic                     command;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [PAYLOAD_BITS-1:0]  entry_payload;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [PRIORITY_BITS-1:0]    out_priority;
    logic [PAYLOAD_BITS-1:0]     out_payload;
    logic [COUNT_FIELD_BITS-1:0] held_count;
  } spq_out_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  payload;
  } spq_entry_t;

  // Broadcast to every cell of the row in each cycle.
  typedef struct packed {
    spq_op_e    op;
    spq_entry_t new_entry;
  } spq_ctrl_t;

endpackage

>>> hdl/spq_cell.sv
// One slot of the sorted row: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               left_keep_i,
  input  spq_pkg::spq_entry_t left_entry_i,
  input  spq_pkg::spq_entry_t right_entry_i,
  output logic               keep_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // An occupied slot whose priority is greater or equal stays ahead of the new entry.
  assign keep_o = occ_i && (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (!keep_o) begin
          entry_d = left_keep_i ? ctrl_i.new_entry : left_entry_i;
        end
      end
      OP_REMOVE: entry_d = right_entry_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> hdl/stable_priority_queue.sv
// Stable priority queue: sorted shift row of cells with a registered result stage.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one command per
// transfer: insert an entry with a priority and payload, or remove the head.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result per command: status, removed priority and payload (zero unless a
// successful remove), and the number of entries held afterwards.
// Entries leave highest priority first; equal priorities leave in arrival order.
// The result is registered at the edge that takes the command. Every cell
// compares against the new priority in parallel and shifts at once, so a
// command can be taken every cycle while the receiver takes each result; the
// single output register sets that limit.
// While a result waits, a new command is taken only in the cycle in which the
// receiver takes the waiting one; a stalled receiver stalls the input.
// Reset empties the queue (count to zero) and drops any pending result; cell
// contents are not cleared and are never read before being written.
// An insert into a full queue and a remove from an empty one leave the queue
// unchanged and report their status.
module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = CW + COUNT_FIELD_BITS;

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  spq_out_t      out_q, out_d;

  logic          accept;
  logic          full, empty;
  spq_ctrl_t     ctrl;
  logic [EW-1:0] count_ext;

  logic       [QUEUE_DEPTH-1:0] occ;
  logic       [QUEUE_DEPTH:0]   keep;
  spq_entry_t                   cell_entry [QUEUE_DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.new_entry.prio    = in_data_i.priority_req;
    ctrl.new_entry.payload = in_data_i.entry_payload;
    ctrl.op                = OP_HOLD;
    if (accept) begin
      if (in_data_i.command == CMD_INSERT && !full) begin
        ctrl.op = OP_INSERT;
      end else if (in_data_i.command == CMD_REMOVE && !empty) begin
        ctrl.op = OP_REMOVE;
      end
    end
  end

  // Row of cells; slot 0 is the head.
  assign keep[0] = 1'b1;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign occ[g] = (count_q > CW'(g));

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[g]),
      .left_keep_i   (keep[g]),
      .left_entry_i  ((g == 0) ? ctrl.new_entry : cell_entry[(g == 0) ? 0 : g - 1]),
      .right_entry_i ((g == QUEUE_DEPTH - 1) ? ctrl.new_entry
                                             : cell_entry[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
      .keep_o        (keep[g+1]),
      .entry_o       (cell_entry[g])
    );
  end

  always_comb begin
    count_d = count_q;
    unique case (ctrl.op)
      OP_INSERT: count_d = count_q + CW'(1);
      OP_REMOVE: count_d = count_q - CW'(1);
      default:   count_d = count_q;
    endcase
  end

  assign count_ext = EW'(count_d);

  always_comb begin
    out_d.status       = STATUS_OK;
    out_d.out_priority = '0;
    out_d.out_payload  = '0;
    out_d.held_count   = count_ext[COUNT_FIELD_BITS-1:0];
    if (in_data_i.command == CMD_INSERT && full) begin
      out_d.status = STATUS_FULL;
    end else if (in_data_i.command == CMD_REMOVE && empty) begin
      out_d.status = STATUS_EMPTY;
    end
    if (ctrl.op == OP_REMOVE) begin
      out_d.out_priority = cell_entry[0].prio;
      out_d.out_payload  = cell_entry[0].payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload register: load on transfer only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.command == CMD_REMOVE && empty)
      |=> (out_valid_o && out_data_o.status == STATUS_EMPTY && $stable(count_q)))
    else $error("remove on empty queue misreported");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.command == CMD_INSERT && !full)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("accepted insert did not grow the queue");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.command == CMD_INSERT && full)
      |=> (out_data_o.status == STATUS_FULL && $stable(count_q)))
    else $error("insert on full queue misreported");

endmodule

>>> tb/sv/stable_priority_queue_tb.sv
// Self-checking testbench for the stable priority queue: directed and random command traffic.
`timescale 1ns / 100ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Keeps its own copy of the queue and the results it must produce.
  class spq_scoreboard;
    logic [PRIORITY_BITS-1:0] held_prio [DEPTH];
    logic [PAYLOAD_BITS-1:0]  held_payload [DEPTH];
    int       held_n;
    spq_out_t awaited_results [$];
    int       errors;
    int       n_inserts;
    int       n_removes;
    int       n_full;
    int       n_empty;
    int       n_peak;

    function new();
      held_n    = 0;
      errors    = 0;
      n_inserts = 0;
      n_removes = 0;
      n_full    = 0;
      n_empty   = 0;
      n_peak    = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Apply one accepted command to the queue copy and store its result.
    function void note_command(spq_in_t cmd);
      spq_out_t res;
      int       pos;
      res = '0;
      if (cmd.command == CMD_INSERT) begin
        n_inserts++;
        if (held_n >= DEPTH) begin
          res.status = STATUS_FULL;
          n_full++;
        end else begin
          // Go behind every entry of greater or equal priority.
          pos = 0;
          while (pos < held_n && held_prio[pos] >= cmd.priority_req) pos++;
          for (int i = held_n; i > pos; i--) begin
            held_prio[i]    = held_prio[i-1];
            held_payload[i] = held_payload[i-1];
          end
          held_prio[pos]    = cmd.priority_req;
          held_payload[pos] = cmd.entry_payload;
          held_n++;
          res.status = STATUS_OK;
        end
      end else begin
        n_removes++;
        if (held_n == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          res.status       = STATUS_OK;
          res.out_priority = held_prio[0];
          res.out_payload  = held_payload[0];
          for (int i = 1; i < held_n; i++) begin
            held_prio[i-1]    = held_prio[i];
            held_payload[i-1] = held_payload[i];
          end
          held_n--;
        end
      end
      if (held_n > n_peak) n_peak = held_n;
      res.held_count = COUNT_FIELD_BITS'(held_n);
      awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned got);
      if (exp != got) begin
        errors++;
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, got);
      end
    endfunction

    function void check_result(spq_out_t got);
      spq_out_t exp;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %0h", $time, got);
        return;
      end
      exp = awaited_results.pop_front();
      compare_field("status", exp.status, got.status);
      compare_field("out_priority", exp.out_priority, got.out_priority);
      compare_field("out_payload", exp.out_payload, got.out_payload);
      compare_field("held_count", exp.held_count, got.held_count);
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spq_out_t out_data_o;

  spq_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  stable_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor both channels and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_command(in_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one command and hold it until the transfer; valid stays high afterwards.
  task automatic send_item(input spq_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Step past the last transfer edge so the monitor has noted it, then wait.
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic spq_in_t make_cmd(spq_cmd_e cmd, int prio, int payload);
    spq_in_t item;
    item.command       = cmd;
    item.priority_req  = PRIORITY_BITS'(prio);
    item.entry_payload = PAYLOAD_BITS'(payload);
    return item;
  endfunction

  // Favor a few priorities so that ties are common.
  function automatic spq_in_t random_cmd(int insert_pct);
    int prio;
    case ($urandom_range(3))
      0: prio = $urandom_range(255);
      1: prio = $urandom_range(3);
      2: prio = 252 + $urandom_range(3);
      default: prio = 128;
    endcase
    return make_cmd(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                    prio, $urandom_range(65535));
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    int insert_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    insert_pct     = 50;
    for (int i = 0; i < n; i++) begin
      // Change the mix in bursts so the queue swings between empty and full.
      if (i % 20 == 0) begin
        case ($urandom_range(3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      send_item(random_cmd(insert_pct));
    end
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: remove on empty with ignored fields set, extremes, ties, fill, full.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(make_cmd(CMD_REMOVE, 255, 16'hFFFF));
    send_item(make_cmd(CMD_INSERT, 0, 16'h0000));
    send_item(make_cmd(CMD_INSERT, 255, 16'hFFFF));
    send_item(make_cmd(CMD_INSERT, 128, 16'h1234));
    send_item(make_cmd(CMD_INSERT, 128, 16'h5678));
    send_item(make_cmd(CMD_INSERT, 255, 16'hA5A5));
    send_item(make_cmd(CMD_INSERT, 0, 16'h5A5A));
    for (int i = 0; i < 10; i++) send_item(make_cmd(CMD_INSERT, 64 + (i % 3), 16'h0100 + i));
    send_item(make_cmd(CMD_INSERT, 200, 16'hDEAD));
    for (int i = 0; i < 4; i++) send_item(make_cmd(CMD_REMOVE, 0, 0));
    in_valid_i <= 1'b0;
    wait_drained();

    run_phase(150, 0, 0);
    run_phase(130, 55, 0);
    run_phase(130, 0, 55);
    run_phase(130, 6, 6);

    // Hold the receiver off while the sender keeps offering, mostly inserts.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 40; i++) send_item(random_cmd(85));
    in_valid_i <= 1'b0;
    wait_drained();

    run_phase(110, 6, 6);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d inserts (%0d rejected full) and %0d removes (%0d on empty),",
             sb.n_inserts, sb.n_full, sb.n_removes, sb.n_empty);
    $display("peak occupancy %0d of %0d, under several idle and stall mixes.",
             sb.n_peak, DEPTH);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
